@@ rtl/conv_mac_requantize_assert.svh @@
// Assertion macros shared by the conv_mac_requantize RTL.
// No dependencies; checks compile away when SYNTHESIS is defined.
`ifndef CONV_MAC_REQUANTIZE_ASSERT_SVH
`define CONV_MAC_REQUANTIZE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CMR_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication, disabled during reset.
`define CMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define CMR_ASSERT(label, clk, rst, ante, cons)
`define CMR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cmr_pkg.sv @@
// Shared types and constants for the convolution MAC / requantizer.
// No dependencies.
package cmr_pkg;

  // Register map, index = paddr[4:2]
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_REQUANT_SHIFT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_BITS      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELU_ENABLE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BIAS_ENABLE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIAS_SCALE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_SCALE     = 3'd5;

  localparam logic [4:0] OUT_BITS_RESET = 5'd8;

  // Rounding is suppressed when the shifted value lands exactly here
  localparam int NO_ROUND_VALUE = 'h7fff;

  localparam int DATA_W = 16;

  // First-stage saturation codes
  localparam logic [1:0] SAT_NONE = 2'd0;
  localparam logic [1:0] SAT_POS  = 2'd1;
  localparam logic [1:0] SAT_NEG  = 2'd2;

  // Window queue between MAC and requantizer
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic [5:0] requant_shift;  // two's complement
    logic [4:0] out_bits;
    logic       relu_enable;
    logic       bias_enable;
    logic [4:0] bias_scale;
    logic [5:0] out_scale;      // two's complement
  } cfg_t;

endpackage

@@ rtl/cmr_front.sv @@
// MAC front end: registers taps, multiplies, accumulates, pushes one
// finished window per last tap into the queue. Depends on cmr_pkg.
module cmr_front #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cmr_pkg::DATA_W-1:0]    feature_value,
  input  logic signed [cmr_pkg::DATA_W-1:0]    weight_value,
  input  logic                                 tap_outside,
  input  logic                                 last_tap,
  input  logic signed [cmr_pkg::DATA_W-1:0]    bias_value,
  output logic                                 push,
  output logic [ACC_WIDTH+cmr_pkg::DATA_W-1:0] push_data,
  input  logic                                 queue_full
);

  logic                               en;
  logic                               a_valid, a_last;
  logic signed [cmr_pkg::DATA_W-1:0]  a_feat, a_wt, a_bias;
  logic                               b_valid, b_last;
  logic signed [2*cmr_pkg::DATA_W-1:0] b_prod;
  logic signed [cmr_pkg::DATA_W-1:0]  b_bias;
  logic signed [ACC_WIDTH-1:0]        acc, acc_sum;

  // Only a window end that cannot enter a full queue holds the pipe
  assign en       = !(b_valid && b_last && queue_full);
  assign in_ready = en;

  assign acc_sum   = acc + ACC_WIDTH'(b_prod);
  assign push      = b_valid && b_last && !queue_full;
  assign push_data = {b_bias, acc_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      acc     <= '0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      if (b_valid) begin
        acc <= b_last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_feat <= tap_outside ? '0 : feature_value;
      a_wt   <= weight_value;
      a_bias <= bias_value;
      a_last <= last_tap;
      b_prod <= a_feat * a_wt;
      b_bias <= a_bias;
      b_last <= a_last;
    end
  end

endmodule

@@ rtl/cmr_fifo.sv @@
// Small window queue decoupling the MAC from the requantizer.
// Depends on cmr_pkg and conv_mac_requantize_assert.svh.
`include "conv_mac_requantize_assert.svh"

module cmr_fifo #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0]                   mem [cmr_pkg::QUEUE_DEPTH];
  logic [cmr_pkg::QUEUE_PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [cmr_pkg::QUEUE_CNT_W-1:0]    count;

  assign full  = (count == cmr_pkg::QUEUE_CNT_W'(cmr_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  `CMR_ASSERT(a_no_push_full, clk, rst, push, !full)
  `CMR_ASSERT(a_no_pop_empty, clk, rst, pop, !empty)
  `CMR_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

@@ rtl/cmr_back.sv @@
// Requantizer back end: shift/round, saturate, bias align/add/round,
// second saturation, ReLU, output register. Depends on cmr_pkg and conv_mac_requantize_assert.svh.
`include "conv_mac_requantize_assert.svh"

module cmr_back #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cmr_pkg::cfg_t                        cfg,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [ACC_WIDTH+cmr_pkg::DATA_W-1:0] q_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cmr_pkg::DATA_W-1:0]           out_data,
  output logic [1:0]                           out_flag
);

  localparam int SW   = (ACC_WIDTH + 1 > 36) ? ACC_WIDTH + 1 : 36;
  localparam int AUXW = 48;
  localparam int SUMW = 49;
  localparam int DW   = cmr_pkg::DATA_W;
  localparam logic signed [SW-1:0] LC_MAX = SW'(2**17 - 1);
  localparam logic signed [SW-1:0] LC_MIN = SW'(-(2**17));

  logic en;
  logic v1, v2, v3, v4;

  // saturation limits from out_bits, clamped to 2..16
  logic [4:0]         bsel;
  logic signed [16:0] lim_max, lim_min;

  always_comb begin
    if (cfg.out_bits < 5'd2)       bsel = 5'd2;
    else if (cfg.out_bits > 5'd16) bsel = 5'd16;
    else                           bsel = cfg.out_bits;
  end
  assign lim_max = $signed((17'd1 << (bsel - 5'd1)) - 17'd1);
  assign lim_min = ~lim_max;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // ---- stage 1: requant shift ----
  logic signed [ACC_WIDTH-1:0] acc, asr, asr_m1;
  logic signed [SW-1:0]        acc_s, right, left, s1_shift_d;
  logic signed [17:0]          acc_c;
  logic [4:0]                  rn, lsc;
  logic [5:0]                  ls;
  logic                        inc1;
  logic signed [DW-1:0]        s1_bias;
  logic signed [SW-1:0]        s1_shift;

  assign acc    = $signed(q_data[ACC_WIDTH-1:0]);
  assign acc_s  = SW'(acc);
  assign rn     = cfg.requant_shift[4:0];
  assign asr    = acc >>> rn;
  assign asr_m1 = acc >>> (rn - 5'd1);
  assign inc1   = (rn != 5'd0) && (SW'(asr) != SW'(cmr_pkg::NO_ROUND_VALUE)) && asr_m1[0];
  assign right  = SW'(asr) + $signed({{(SW-1){1'b0}}, inc1});

  // a value beyond 18 bits saturates after any left shift, as does a shift past 18
  assign ls  = 6'(-$signed(cfg.requant_shift));
  assign lsc = (ls > 6'd18) ? 5'd18 : ls[4:0];
  always_comb begin
    if (acc_s > LC_MAX)      acc_c = 18'sh1ffff;
    else if (acc_s < LC_MIN) acc_c = 18'sh20000;
    else                     acc_c = acc_s[17:0];
  end
  assign left       = SW'(acc_c) <<< lsc;
  assign s1_shift_d = cfg.requant_shift[5] ? left : right;

  // ---- stage 2: first saturation, bias alignment ----
  logic signed [DW-1:0]   sat_d, bq, s2_sat;
  logic [1:0]             flag_d, s2_flag;
  logic [5:0]             bn;
  logic signed [DW-1:0]   bq_m1;
  logic signed [AUXW-1:0] aux_d, s2_aux;

  always_comb begin
    if (s1_shift < lim_min) begin
      sat_d  = DW'(lim_min);
      flag_d = cmr_pkg::SAT_NEG;
    end else if (s1_shift > lim_max) begin
      sat_d  = DW'(lim_max);
      flag_d = cmr_pkg::SAT_POS;
    end else begin
      sat_d  = DW'(s1_shift);
      flag_d = cmr_pkg::SAT_NONE;
    end
  end

  // A 16-bit bias shifted right can never hit the no-round value
  assign bn    = 6'(-$signed(cfg.out_scale));
  assign bq    = s1_bias >>> bn;
  assign bq_m1 = s1_bias >>> (bn - 6'd1);
  assign aux_d = cfg.out_scale[5]
               ? AUXW'(bq) + $signed({{(AUXW-1){1'b0}}, bq_m1[0]})
               : AUXW'(s1_bias) <<< cfg.out_scale[4:0];

  // ---- stage 3: aligned add ----
  logic signed [AUXW-1:0] main_part;
  logic signed [SUMW-1:0] s3_sum;
  logic signed [DW-1:0]   s3_sat;
  logic [1:0]             s3_flag;

  assign main_part = AUXW'(s2_sat) <<< cfg.bias_scale;

  // ---- stage 4: rounding shift back ----
  logic signed [SUMW-1:0] r4, r4_m1, s4_rnd;
  logic signed [DW-1:0]   s4_sat;
  logic [1:0]             s4_flag;
  logic                   inc4;

  assign r4    = s3_sum >>> cfg.bias_scale;
  assign r4_m1 = s3_sum >>> (cfg.bias_scale - 5'd1);
  assign inc4  = (cfg.bias_scale != 5'd0) &&
                 (r4 != SUMW'(cmr_pkg::NO_ROUND_VALUE)) && r4_m1[0];

  // ---- stage 5: second saturation, ReLU ----
  logic signed [DW-1:0] bsat, fin;

  always_comb begin
    if (s4_rnd < lim_min)      bsat = DW'(lim_min);
    else if (s4_rnd > lim_max) bsat = DW'(lim_max);
    else                       bsat = DW'(s4_rnd);
    fin = cfg.bias_enable ? bsat : s4_sat;
    if (cfg.relu_enable && fin[DW-1]) fin = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= q_pop;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_shift <= s1_shift_d;
      s1_bias  <= $signed(q_data[ACC_WIDTH+DW-1:ACC_WIDTH]);
      s2_sat   <= sat_d;
      s2_flag  <= flag_d;
      s2_aux   <= aux_d;
      s3_sum   <= SUMW'(main_part) + SUMW'(s2_aux);
      s3_sat   <= s2_sat;
      s3_flag  <= s2_flag;
      s4_rnd   <= r4 + $signed({{(SUMW-1){1'b0}}, inc4});
      s4_sat   <= s3_sat;
      s4_flag  <= s3_flag;
      out_data <= fin;
      out_flag <= s4_flag;
    end
  end

  `CMR_ASSERT(a_relu_nonneg, clk, rst, out_valid && cfg.relu_enable, !out_data[DW-1])
  `CMR_ASSERT(a_in_limits, clk, rst, out_valid, ($signed(out_data) <= lim_max) && ($signed(out_data) >= lim_min))

endmodule

@@ rtl/conv_mac_requantize.sv @@
// Top level of the quantized convolution MAC with requantization.
// Depends on cmr_pkg, cmr_front, cmr_fifo, cmr_back.

// Takes one convolution tap per beat on the slave stream and returns one
// requantized pixel on the master stream for every beat that carries tlast.
// Throughput is one tap per clock, set by the front end's single 16x16
// multiplier and accumulator add. The tap input stalls only while a finished
// window sits in the front end's last stage and the four-entry window queue
// is full. A window's result passes through the two front stages, the window
// queue and the five back stages before it shows up on m_axis_tvalid.
// The back end stalls only on master-side backpressure; the queue
// lets the MAC keep taking taps meanwhile.
// Registers (APB, byte address 4*index): 0 requant_shift, 1 out_bits,
// 2 relu_enable, 3 bias_enable, 4 bias_scale, 5 out_scale. Change them only
// while no window is in flight.
module conv_mac_requantize #(
  parameter int ACC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // tap stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // feature_value[15:0], weight_value[31:16],
                                      // bias_value[47:32]
  input  logic        s_axis_tuser,   // tap_outside
  input  logic        s_axis_tlast,   // last_tap
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result_value[15:0]
  output logic [1:0]  m_axis_tuser,   // saturation[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = ACC_WIDTH + cmr_pkg::DATA_W;

  cmr_pkg::cfg_t cfg;
  logic          wr_en;
  logic [cmr_pkg::REG_IDX_W-1:0] reg_idx;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.requant_shift <= '0;
      cfg.out_bits      <= cmr_pkg::OUT_BITS_RESET;
      cfg.relu_enable   <= 1'b0;
      cfg.bias_enable   <= 1'b0;
      cfg.bias_scale    <= '0;
      cfg.out_scale     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        cmr_pkg::REG_REQUANT_SHIFT: cfg.requant_shift <= pwdata[5:0];
        cmr_pkg::REG_OUT_BITS:      cfg.out_bits      <= pwdata[4:0];
        cmr_pkg::REG_RELU_ENABLE:   cfg.relu_enable   <= pwdata[0];
        cmr_pkg::REG_BIAS_ENABLE:   cfg.bias_enable   <= pwdata[0];
        cmr_pkg::REG_BIAS_SCALE:    cfg.bias_scale    <= pwdata[4:0];
        cmr_pkg::REG_OUT_SCALE:     cfg.out_scale     <= pwdata[5:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cmr_pkg::REG_REQUANT_SHIFT: prdata = 32'(cfg.requant_shift);
      cmr_pkg::REG_OUT_BITS:      prdata = 32'(cfg.out_bits);
      cmr_pkg::REG_RELU_ENABLE:   prdata = 32'(cfg.relu_enable);
      cmr_pkg::REG_BIAS_ENABLE:   prdata = 32'(cfg.bias_enable);
      cmr_pkg::REG_BIAS_SCALE:    prdata = 32'(cfg.bias_scale);
      cmr_pkg::REG_OUT_SCALE:     prdata = 32'(cfg.out_scale);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  cmr_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .feature_value ($signed(s_axis_tdata[15:0])),
    .weight_value  ($signed(s_axis_tdata[31:16])),
    .tap_outside   (s_axis_tuser),
    .last_tap      (s_axis_tlast),
    .bias_value    ($signed(s_axis_tdata[47:32])),
    .push          (q_push),
    .push_data     (q_wdata),
    .queue_full    (q_full)
  );

  // finished windows wait here: {bias, accumulator}
  cmr_fifo #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cmr_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser)
  );

endmodule
